@@ rtl/imu_fyu_pkg.sv @@
// Shared types, codes and constants for the IMU frame yaw unwrapper.
package imu_fyu_pkg;

    localparam int FRAME_LENGTH_DEF = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESH = 2'd2;

    localparam logic [7:0]  SYNC_BYTE_RST   = 8'h55;
    localparam logic [7:0]  ANGLE_TYPE_RST  = 8'h53;
    localparam logic [15:0] WRAP_THRESH_RST = 16'd45511;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic signed [15:0] TURNS_MAX = 16'sd32767;
    localparam logic signed [15:0] TURNS_MIN = -16'sd32767;

    // Frame byte positions that are kept
    localparam int POS_TYPE    = 1;
    localparam int POS_YAW_LOW = 6;
    localparam int POS_YAW_HI  = 7;

    typedef struct packed {
        logic        valid;
        logic [15:0] yaw;
    } t_frame_evt;

    typedef struct packed {
        logic signed [31:0] angle;
        logic [15:0]        raw_yaw;
        logic signed [15:0] turns;
    } t_unwrap_res;

endpackage

@@ rtl/imu_fyu_if.sv @@
// Valid/ready channel interfaces for received bytes and unwrapped yaw results.
interface imu_fyu_byte_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface imu_fyu_yaw_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] unwrapped_angle;
    logic [15:0]        raw_yaw;
    logic signed [15:0] turn_count;

    modport source (output valid, output unwrapped_angle, output raw_yaw, output turn_count,
                    input ready);
    modport sink   (input valid, input unwrapped_angle, input raw_yaw, input turn_count,
                    output ready);
endinterface

@@ rtl/imu_frame_yaw_unwrapper_unit.sv @@
// Top level of the IMU frame yaw unwrapper: registers, parser, unwrapper and result register.
// Takes one received byte (or a clear request) per cycle and turns completed angle frames
// into a continuous yaw in 360/65536 degree units. Bytes are dropped until the sync byte is
// seen; FRAME_LENGTH bytes then make a frame, whose type byte is frame byte 1 and whose yaw is
// frame bytes 6 (low) and 7 (high); the checksum is not checked. A yaw jump beyond the wrap
// threshold steps the turn count, which saturates at +/-32767. A clear zeroes the previous
// yaw and the turn count without disturbing frame parsing and gives no result. Each transfer
// in is handled in the cycle it is taken and its result, if any, enters the output register
// at the end of that cycle, so the block sustains one byte per cycle; input ready only drops
// while a result sits in the output register and the sink is not taking it. Configuration
// writes must be made while the block is idle.
module imu_frame_yaw_unwrapper_unit #(
    parameter int FRAME_LENGTH = imu_fyu_pkg::FRAME_LENGTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imu_fyu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imu_fyu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    imu_fyu_byte_if.sink                       i_in,
    imu_fyu_yaw_if.source                      o_out
);
    import imu_fyu_pkg::*;

    logic [7:0]  r_sync_byte;
    logic [7:0]  r_angle_type;
    logic [15:0] r_wrap_thresh;

    logic        w_free;
    logic        w_accept;
    logic        w_byte_vld;
    logic        w_clear;
    t_frame_evt  w_evt;
    t_unwrap_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte   <= SYNC_BYTE_RST;
            r_angle_type  <= ANGLE_TYPE_RST;
            r_wrap_thresh <= WRAP_THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_BYTE:   r_sync_byte   <= i_cfg_data[7:0];
                CFG_ANGLE_TYPE:  r_angle_type  <= i_cfg_data[7:0];
                CFG_WRAP_THRESH: r_wrap_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && w_free;
    assign w_byte_vld = w_accept && (i_in.opcode == OP_BYTE);
    assign w_clear    = w_accept && (i_in.opcode == OP_CLEAR);

    imu_fyu_parser #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_vld   (w_byte_vld),
        .i_rx_byte    (i_in.rx_byte),
        .i_sync_byte  (r_sync_byte),
        .i_angle_type (r_angle_type),
        .o_evt        (w_evt)
    );

    imu_fyu_unwrap u_unwrap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (w_clear),
        .i_evt         (w_evt),
        .i_wrap_thresh (r_wrap_thresh),
        .o_res         (w_res)
    );

    imu_fyu_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_evt.valid),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // Turn count saturates symmetrically
    a_turns_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.turn_count != 16'sh8000))
        else $error("turn count left its saturation range");

    a_angle_low_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.unwrapped_angle[15:0] == o_out.raw_yaw))
        else $error("unwrapped angle low half differs from raw yaw");

    a_angle_high_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.unwrapped_angle[31:16] == 16'(-o_out.turn_count)))
        else $error("unwrapped angle high half does not match turn count");

    // A delivered result with no new frame behind it leaves the register empty
    a_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !w_evt.valid) |=> !o_out.valid)
        else $error("result repeated after transfer");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while result register is stalled");
`endif

endmodule

@@ rtl/imu_fyu_parser.sv @@
// Sync hunt and frame byte collection; flags completed angle frames with their yaw.
module imu_fyu_parser #(
    parameter int FRAME_LENGTH = imu_fyu_pkg::FRAME_LENGTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_byte_vld,
    input  logic [7:0]              i_rx_byte,
    input  logic [7:0]              i_sync_byte,
    input  logic [7:0]              i_angle_type,
    output imu_fyu_pkg::t_frame_evt o_evt
);
    import imu_fyu_pkg::*;

    localparam int POS_W = $clog2(FRAME_LENGTH + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_yaw_lo, n_yaw_lo;
    logic [7:0]       r_yaw_hi, n_yaw_hi;
    logic             w_take;
    logic             w_last;

    assign w_take = i_byte_vld && !(r_pos == '0 && i_rx_byte != i_sync_byte);
    assign w_last = (r_pos == POS_W'(FRAME_LENGTH - 1));

    always_comb begin
        n_pos    = r_pos;
        n_type   = r_type;
        n_yaw_lo = r_yaw_lo;
        n_yaw_hi = r_yaw_hi;
        if (w_take) begin
            if (r_pos == POS_W'(POS_TYPE))    n_type   = i_rx_byte;
            if (r_pos == POS_W'(POS_YAW_LOW)) n_yaw_lo = i_rx_byte;
            if (r_pos == POS_W'(POS_YAW_HI))  n_yaw_hi = i_rx_byte;
            n_pos = w_last ? '0 : r_pos + 1'b1;
        end
    end

    // Uses next values so a frame ending on the yaw high byte still sees it
    always_comb begin
        o_evt.valid = w_take && w_last && (n_type == i_angle_type);
        o_evt.yaw   = {n_yaw_hi, n_yaw_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_type   <= '0;
            r_yaw_lo <= '0;
            r_yaw_hi <= '0;
        end else begin
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_yaw_lo <= n_yaw_lo;
            r_yaw_hi <= n_yaw_hi;
        end
    end

endmodule

@@ rtl/imu_fyu_unwrap.sv @@
// Turn counting against the previous yaw and continuous angle formation.
module imu_fyu_unwrap (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  imu_fyu_pkg::t_frame_evt  i_evt,
    input  logic [15:0]              i_wrap_thresh,
    output imu_fyu_pkg::t_unwrap_res o_res
);
    import imu_fyu_pkg::*;

    logic [15:0]        r_prev_yaw, n_prev_yaw;
    logic signed [15:0] r_turns, n_turns;
    logic [16:0]        w_diff;
    logic [15:0]        w_up_mag;
    logic [15:0]        w_dn_mag;
    logic               w_jump_up;
    logic               w_jump_dn;
    logic [15:0]        w_neg_turns;

    assign w_diff    = {1'b0, i_evt.yaw} - {1'b0, r_prev_yaw};
    assign w_up_mag  = w_diff[15:0];
    assign w_dn_mag  = r_prev_yaw - i_evt.yaw;
    assign w_jump_up = !w_diff[16] && (w_up_mag > i_wrap_thresh);
    assign w_jump_dn =  w_diff[16] && (w_dn_mag > i_wrap_thresh);

    always_comb begin
        n_prev_yaw = r_prev_yaw;
        n_turns    = r_turns;
        if (i_clear) begin
            n_prev_yaw = '0;
            n_turns    = '0;
        end else if (i_evt.valid) begin
            n_prev_yaw = i_evt.yaw;
            if (w_jump_up && r_turns < TURNS_MAX) n_turns = r_turns + 16'sd1;
            else if (w_jump_dn && r_turns > TURNS_MIN) n_turns = r_turns - 16'sd1;
        end
    end

    // raw - turns*65536: low half is raw, high half is -turns (never overflows)
    assign w_neg_turns = 16'(-n_turns);

    always_comb begin
        o_res.angle   = $signed({w_neg_turns, i_evt.yaw});
        o_res.raw_yaw = i_evt.yaw;
        o_res.turns   = n_turns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_yaw <= '0;
            r_turns    <= '0;
        end else begin
            r_prev_yaw <= n_prev_yaw;
            r_turns    <= n_turns;
        end
    end

endmodule

@@ rtl/imu_fyu_out_reg.sv @@
// Result register holding one yaw result until its transfer completes.
module imu_fyu_out_reg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  imu_fyu_pkg::t_unwrap_res i_res,
    output logic                     o_free,
    imu_fyu_yaw_if.source            o_out
);
    import imu_fyu_pkg::*;

    logic        r_valid, n_valid;
    t_unwrap_res r_res;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) n_valid = i_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.unwrapped_angle = r_res.angle;
    assign o_out.raw_yaw         = r_res.raw_yaw;
    assign o_out.turn_count      = r_res.turns;

endmodule

@@ tb/imu_fyu_yaw_checker.sv @@
// Checker for the IMU frame yaw unwrapper: tracks transfers, predicts results and compares.
`timescale 1ns / 100ps

module imu_fyu_yaw_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imu_fyu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imu_fyu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    imu_fyu_byte_if                            i_in,
    imu_fyu_yaw_if                             i_out,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import imu_fyu_pkg::*;

    logic [7:0]         sync_val;
    logic [7:0]         angle_type_val;
    logic [15:0]        wrap_thresh_val;

    logic [3:0]         frame_pos;
    logic [7:0]         frame_type_b;
    logic [7:0]         yaw_lo_b;
    logic [7:0]         yaw_hi_b;
    logic [15:0]        last_yaw;
    logic signed [15:0] turn_ctr;

    t_unwrap_res        expected_yaw_q[$];

    // One received byte or clear through the parser and unwrapper.
    task automatic predict_unwrap(input logic op, input logic [7:0] b,
                                  output bit produced, output t_unwrap_res res);
        int raw;
        int diff;
        produced = 1'b0;
        res      = '0;
        if (op == OP_CLEAR) begin
            last_yaw = '0;
            turn_ctr = '0;
            return;
        end
        if (frame_pos == 0 && b != sync_val)
            return;
        case (frame_pos)
            POS_TYPE:    frame_type_b = b;
            POS_YAW_LOW: yaw_lo_b     = b;
            POS_YAW_HI:  yaw_hi_b     = b;
            default: ;
        endcase
        frame_pos = frame_pos + 4'd1;
        if (frame_pos < FRAME_LENGTH_DEF)
            return;
        frame_pos = '0;
        if (frame_type_b != angle_type_val)
            return;
        raw  = int'({yaw_hi_b, yaw_lo_b});
        diff = raw - int'(last_yaw);
        last_yaw = raw[15:0];
        if (diff > int'(wrap_thresh_val)) begin
            if (turn_ctr < TURNS_MAX)
                turn_ctr = turn_ctr + 16'sd1;
        end else if (-diff > int'(wrap_thresh_val)) begin
            if (turn_ctr > TURNS_MIN)
                turn_ctr = turn_ctr - 16'sd1;
        end
        res.angle   = raw - int'(turn_ctr) * 65536;
        res.raw_yaw = raw[15:0];
        res.turns   = turn_ctr;
        produced    = 1'b1;
    endtask

    always @(posedge i_clk) begin
        bit          got;
        t_unwrap_res res;
        t_unwrap_res exp_res;
        if (!i_rst_n) begin
            sync_val        = SYNC_BYTE_RST;
            angle_type_val  = ANGLE_TYPE_RST;
            wrap_thresh_val = WRAP_THRESH_RST;
            frame_pos       = '0;
            frame_type_b    = '0;
            yaw_lo_b        = '0;
            yaw_hi_b        = '0;
            last_yaw        = '0;
            turn_ctr        = '0;
            expected_yaw_q.delete();
        end else begin
            // outgoing transfer first: a result never stems from this edge's input
            if (i_out.valid && i_out.ready) begin
                if (expected_yaw_q.size() == 0) begin
                    $error("unexpected result: angle %0d raw_yaw %0d turn_count %0d",
                           i_out.unwrapped_angle, i_out.raw_yaw, i_out.turn_count);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_res = expected_yaw_q.pop_front();
                    if (i_out.unwrapped_angle !== exp_res.angle) begin
                        $error("unwrapped_angle: expected %0d, actual %0d",
                               exp_res.angle, i_out.unwrapped_angle);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out.raw_yaw !== exp_res.raw_yaw) begin
                        $error("raw_yaw: expected %0d, actual %0d",
                               exp_res.raw_yaw, i_out.raw_yaw);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out.turn_count !== exp_res.turns) begin
                        $error("turn_count: expected %0d, actual %0d",
                               exp_res.turns, i_out.turn_count);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_unwrap(i_in.opcode, i_in.rx_byte, got, res);
                if (got)
                    expected_yaw_q.push_back(res);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_BYTE:   sync_val        = i_cfg_data[7:0];
                    CFG_ANGLE_TYPE:  angle_type_val  = i_cfg_data[7:0];
                    CFG_WRAP_THRESH: wrap_thresh_val = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_yaw_q.size();
    end

endmodule

@@ tb/imu_frame_yaw_unwrapper_unit_tb.sv @@
// Testbench top for the IMU frame yaw unwrapper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module imu_frame_yaw_unwrapper_unit_tb;
    import imu_fyu_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    bit                    stall_on;
    logic [7:0]            cur_sync;
    logic [7:0]            cur_type;
    logic [15:0]           cur_thresh;
    logic [15:0]           last_yaw;
    int                    burst_items;

    imu_fyu_byte_if byte_ch();
    imu_fyu_yaw_if  yaw_ch();

    imu_frame_yaw_unwrapper_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (byte_ch),
        .o_out       (yaw_ch)
    );

    imu_fyu_yaw_checker yaw_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in         (byte_ch),
        .i_out        (yaw_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure
    initial begin
        yaw_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            yaw_ch.ready <= stall_on ? ($urandom_range(99) >= 36) : 1'b1;
        end
    end

    // Starts and ends at a falling edge; returns once the transfer has happened.
    task automatic send_xfer(input logic op, input logic [7:0] b);
        if (stall_on && $urandom_range(99) < 25) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.opcode  <= op;
        byte_ch.rx_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        burst_items++;
        if (op == OP_CLEAR)
            last_yaw = '0;
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] yaw,
                              input bit noisy, input int clear_at);
        logic [7:0] b;
        for (int pos = 0; pos < FRAME_LENGTH_DEF; pos++) begin
            if (pos == clear_at || (noisy && $urandom_range(99) < 3))
                send_xfer(OP_CLEAR, 8'($urandom_range(255)));
            case (pos)
                0:           b = cur_sync;
                POS_TYPE:    b = ftype;
                POS_YAW_LOW: b = yaw[7:0];
                POS_YAW_HI:  b = yaw[15:8];
                default:     b = 8'($urandom_range(255));
            endcase
            send_xfer(OP_BYTE, b);
        end
        if (ftype == cur_type)
            last_yaw = yaw;
    endtask

    function automatic logic [15:0] pick_yaw();
        logic [31:0] y;
        case ($urandom_range(5))
            // either side of the strict wrap compare
            0: y = last_yaw + cur_thresh + $urandom_range(1);
            1: y = last_yaw - cur_thresh - $urandom_range(1);
            2: y = last_yaw + $urandom_range(64) - 32;
            3: y = $urandom_range(1) ? 32'h0 : 32'hFFFF;
            default: y = $urandom_range(16'hFFFF);
        endcase
        return y[15:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_SYNC_BYTE:   cur_sync   = val[7:0];
            CFG_ANGLE_TYPE:  cur_type   = val[7:0];
            CFG_WRAP_THRESH: cur_thresh = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly whole frames with random content; strays, clears and cut-off frames between.
    task automatic random_traffic(input int n_items);
        int r;
        int stray_save;
        burst_items = 0;
        while (burst_items < n_items) begin
            r = $urandom_range(99);
            if (r < 80) begin
                send_frame(($urandom_range(99) < 80) ? cur_type : 8'($urandom_range(255)),
                           pick_yaw(), 1'b1, -1);
            end else if (r < 90) begin
                stray_save = burst_items;
                repeat ($urandom_range(1, 3)) send_xfer(OP_BYTE, 8'($urandom_range(255)));
                burst_items = stray_save;
            end else if (r < 95) begin
                send_xfer(OP_CLEAR, 8'($urandom_range(255)));
            end else begin
                send_xfer(OP_BYTE, cur_sync);
                repeat ($urandom_range(1, 8)) send_xfer(OP_BYTE, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input logic [7:0] sync_v, input logic [7:0] type_v,
                             input logic [15:0] thresh_v, input int n_items, input bit stalls);
        write_reg(CFG_SYNC_BYTE, {8'($urandom_range(255)), sync_v});
        write_reg(CFG_ANGLE_TYPE, {8'($urandom_range(255)), type_v});
        write_reg(CFG_WRAP_THRESH, thresh_v);
        stall_on = stalls;
        random_traffic(n_items);
        drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.opcode  = OP_BYTE;
        byte_ch.rx_byte = '0;
        stall_on        = 1'b1;
        cur_sync        = SYNC_BYTE_RST;
        cur_type        = ANGLE_TYPE_RST;
        cur_thresh      = WRAP_THRESH_RST;
        last_yaw        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset settings
        send_xfer(OP_BYTE, 8'h00);
        send_xfer(OP_BYTE, 8'hFF);
        send_xfer(OP_CLEAR, 8'hFF);
        send_frame(cur_type, 16'hFFFF, 1'b0, -1);   // upward jump
        send_frame(cur_type, 16'h0000, 1'b0, -1);   // downward jump
        send_frame(cur_type, WRAP_THRESH_RST, 1'b0, -1); // jump equal to threshold
        send_frame(8'h51, 16'h1234, 1'b0, 4);       // other type, clear mid-frame
        drain();

        stall_on = 1'b1;
        random_traffic(300);
        drain();

        write_reg(CFG_IDX_UNUSED, 16'($urandom_range(16'hFFFF)));
        run_phase(8'h00, 8'hFF, 16'h0000, 250, 1'b1);
        run_phase(8'hFF, 8'h00, 16'hFFFF, 250, 1'b1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(16'hFFFF)), 300, 1'b0);
        run_phase(SYNC_BYTE_RST, ANGLE_TYPE_RST, 16'h8000, 200, 1'b1);
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(16'hFFFF)), 200, 1'b1);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/imu_fyu_pkg.sv
rtl/imu_fyu_if.sv
rtl/imu_fyu_parser.sv
rtl/imu_fyu_unwrap.sv
rtl/imu_fyu_out_reg.sv
rtl/imu_frame_yaw_unwrapper_unit.sv
tb/imu_fyu_yaw_checker.sv
tb/imu_frame_yaw_unwrapper_unit_tb.sv
